// ===== rtl/core/klop_pkg.sv =====
// shared constants, codes and state type for the keyed lru object pool
package klop_pkg;

    localparam int POOL_DEPTH_DEF = 16;

    localparam int CMD_W      = 2;
    localparam int DIM_W      = 14;
    localparam int HANDLE_W   = 16;
    localparam int KIND_W     = 3;
    localparam int LIMIT_W    = 5;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [LIMIT_W-1:0]   LIMIT_RESET    = 5'd16;
    localparam logic [REG_IDX_W-1:0] REG_POOL_LIMIT = '0;

    localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RECYCLE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PURGE   = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_HIT     = 3'd0,
        KIND_MISS    = 3'd1,
        KIND_STORED  = 3'd2,
        KIND_RELEASE = 3'd3,
        KIND_NONE    = 3'd4
    } klop_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ACQ_SCAN,
        ST_SHIFT_UP,
        ST_INS_START,
        ST_SHIFT_DN,
        ST_INSERT,
        ST_EV_RD,
        ST_EV_OUT,
        ST_PURGE
    } klop_state_t;

endpackage

// ===== rtl/core/klop_ram.sv =====
// generic single write port ram with registered read
module klop_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/klop_cfg.sv =====
// apb register block holding the pool limit
module klop_cfg
    import klop_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [LIMIT_W-1:0]    pool_limit
);

    logic [LIMIT_W-1:0]   pool_limit_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_limit_reg <= LIMIT_RESET;
        end
        else if (wr_en && (reg_idx == REG_POOL_LIMIT))
        begin
            pool_limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_POOL_LIMIT: prdata = APB_DATA_W'(pool_limit_reg);
            default:        prdata = '0;
        endcase
    end

    assign pool_limit = pool_limit_reg;

endmodule

// ===== rtl/core/keyed_lru_object_pool_core.sv =====
// keyed lru object pool: recency-ordered handle store with a scan sequencer
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+------------------------------------------
//  request   | start, busy (taken on !busy)  | cmd, width, height, handle,
//            |                               | handle_width, handle_height
//  result    | result_valid (one-cycle pulse)| result_kind, out_handle, out_width,
//            |                               | out_height, last
//  config    | apb psel/penable/pwrite       | paddr, pwdata, prdata, pready
//
// entries sit in one ram ordered by recency (position 0 most recent), so every
// operation is a walk of the ram, one position per cycle.
// acquire: scan from position 0 for the key; on a hit shift every entry behind it up one.
// recycle: shift every entry down one and store at position 0, releasing the oldest
// after it when over the limit or before it when full; purge releases every entry.
// busy stays high until the walk that closes a transaction is over, and results
// are pushed out as a pulse: the receiver cannot stall them.
// reset empties the pool at once (fill count to zero); no clearing pass is needed.
module keyed_lru_object_pool_core
    import klop_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  start,
    output logic                  busy,
    input  logic [CMD_W-1:0]      cmd,
    input  logic [DIM_W-1:0]      width,
    input  logic [DIM_W-1:0]      height,
    input  logic [HANDLE_W-1:0]   handle,
    input  logic [DIM_W-1:0]      handle_width,
    input  logic [DIM_W-1:0]      handle_height,
    // result channel
    output logic                  result_valid,
    output logic [KIND_W-1:0]     result_kind,
    output logic [HANDLE_W-1:0]   out_handle,
    output logic [DIM_W-1:0]      out_width,
    output logic [DIM_W-1:0]      out_height,
    output logic                  last,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

    // one cached buffer: handle and its key
    typedef struct packed {
        logic [HANDLE_W-1:0] hnd;
        logic [DIM_W-1:0]    wid;
        logic [DIM_W-1:0]    hgt;
    } entry_t;

    // one result transaction
    typedef struct packed {
        klop_kind_t          kind;
        logic [HANDLE_W-1:0] hnd;
        logic [DIM_W-1:0]    wid;
        logic [DIM_W-1:0]    hgt;
        logic                fin;
    } result_t;

    function automatic result_t make_result(
        input klop_kind_t          kind,
        input logic [HANDLE_W-1:0] hnd,
        input logic [DIM_W-1:0]    wid,
        input logic [DIM_W-1:0]    hgt,
        input logic                fin
    );
        result_t r;
        r.kind = kind;
        r.hnd  = hnd;
        r.wid  = wid;
        r.hgt  = hgt;
        r.fin  = fin;
        return r;
    endfunction

    // sequencer state
    klop_state_t     state_reg, state_next;
    logic [AW-1:0]   ptr_reg, ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            pre_evict_reg, pre_evict_next;

    // captured request
    logic [CMD_W-1:0]    req_cmd_reg;
    logic [DIM_W-1:0]    req_width_reg;
    logic [DIM_W-1:0]    req_height_reg;
    logic [HANDLE_W-1:0] req_handle_reg;
    logic [DIM_W-1:0]    req_hwidth_reg;
    logic [DIM_W-1:0]    req_hheight_reg;

    // result register
    logic    res_valid_reg, res_valid_next;
    result_t res_reg, res_next;

    // ram port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    entry_t        ram_wdata;
    entry_t        ram_rdata;

    logic [LIMIT_W-1:0] pool_limit;
    logic               accept;
    logic [CW-1:0]      cnt_m1;
    logic [CW-1:0]      cnt_m2;
    logic [AW-1:0]      ptr_p1;
    logic [AW-1:0]      ptr_p2;
    logic [AW-1:0]      ptr_m1;
    logic               ptr_is_last;
    logic               ptr_is_pen;
    logic               key_match;
    logic               pool_full;
    logic [LW-1:0]      lim_ext;
    logic [LW-1:0]      depth_ext;
    logic [LW-1:0]      lim_eff;
    logic               over_limit;

    klop_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .pool_limit (pool_limit)
    );

    klop_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (POOL_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // position arithmetic for the walk
    assign cnt_m1      = count_reg - CW'(1);
    assign cnt_m2      = count_reg - CW'(2);
    assign ptr_p1      = ptr_reg + AW'(1);
    assign ptr_p2      = ptr_reg + AW'(2);
    assign ptr_m1      = ptr_reg - AW'(1);
    assign ptr_is_last = (CW'(ptr_reg) == cnt_m1);
    assign ptr_is_pen  = (CW'(ptr_reg) == cnt_m2);
    assign key_match   = (ram_rdata.wid == req_width_reg) && (ram_rdata.hgt == req_height_reg);
    assign pool_full   = (count_reg >= CW'(POOL_DEPTH));

    // limit in force is the smaller of the register and the pool depth
    assign lim_ext    = LW'(pool_limit);
    assign depth_ext  = LW'(POOL_DEPTH);
    assign lim_eff    = (lim_ext < depth_ext) ? lim_ext : depth_ext;
    // count before the insert at or above the limit: over the limit after it
    assign over_limit = (LW'(count_reg) >= lim_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            count_reg     <= '0;
            pre_evict_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            count_reg     <= count_next;
            pre_evict_reg <= pre_evict_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept)
        begin
            req_cmd_reg     <= cmd;
            req_width_reg   <= width;
            req_height_reg  <= height;
            req_handle_reg  <= handle;
            req_hwidth_reg  <= handle_width;
            req_hheight_reg <= handle_height;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        count_next     = count_reg;
        pre_evict_next = pre_evict_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_waddr      = ptr_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = ptr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                pre_evict_next = 1'b0;
                case (req_cmd_reg)
                    CMD_ACQUIRE:
                    begin
                        if (count_reg == '0)
                        begin
                            res_valid_next = 1'b1;
                            res_next       = make_result(KIND_MISS, '0, req_width_reg,
                                                         req_height_reg, 1'b1);
                            state_next     = ST_IDLE;
                        end
                        else
                        begin
                            // fetch the most recent entry first
                            ram_raddr  = '0;
                            ptr_next   = '0;
                            state_next = ST_ACQ_SCAN;
                        end
                    end
                    CMD_RECYCLE:
                    begin
                        if (req_handle_reg == '0)
                        begin
                            // null handle is ignored
                            res_valid_next = 1'b1;
                            res_next       = make_result(KIND_NONE, '0, '0, '0, 1'b1);
                            state_next     = ST_IDLE;
                        end
                        else if (pool_full)
                        begin
                            // no free slot: release the oldest before storing
                            ram_raddr      = cnt_m1[AW-1:0];
                            pre_evict_next = 1'b1;
                            state_next     = ST_EV_OUT;
                        end
                        else
                        begin
                            state_next = ST_INS_START;
                        end
                    end
                    CMD_PURGE:
                    begin
                        if (count_reg == '0)
                        begin
                            res_valid_next = 1'b1;
                            res_next       = make_result(KIND_NONE, '0, '0, '0, 1'b1);
                            state_next     = ST_IDLE;
                        end
                        else
                        begin
                            ram_raddr  = '0;
                            ptr_next   = '0;
                            state_next = ST_PURGE;
                        end
                    end
                    default:
                    begin
                        res_valid_next = 1'b1;
                        res_next       = make_result(KIND_NONE, '0, '0, '0, 1'b1);
                        state_next     = ST_IDLE;
                    end
                endcase
            end

            ST_ACQ_SCAN:
            begin
                // read one ahead; on a hit that read feeds the compaction
                ram_raddr = ptr_p1;
                if (key_match)
                begin
                    res_valid_next = 1'b1;
                    res_next       = make_result(KIND_HIT, ram_rdata.hnd, req_width_reg,
                                                 req_height_reg, 1'b1);
                    if (ptr_is_last)
                    begin
                        count_next = cnt_m1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SHIFT_UP;
                    end
                end
                else if (ptr_is_last)
                begin
                    res_valid_next = 1'b1;
                    res_next       = make_result(KIND_MISS, '0, req_width_reg,
                                                 req_height_reg, 1'b1);
                    state_next     = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_p1;
                end
            end

            ST_SHIFT_UP:
            begin
                // close the gap: position ptr takes the entry behind it
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_wdata = ram_rdata;
                ram_raddr = ptr_p2;
                if (ptr_is_pen)
                begin
                    count_next = cnt_m1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_p1;
                end
            end

            ST_INS_START:
            begin
                if (count_reg == '0)
                begin
                    state_next = ST_INSERT;
                end
                else
                begin
                    ram_raddr  = cnt_m1[AW-1:0];
                    ptr_next   = cnt_m1[AW-1:0];
                    state_next = ST_SHIFT_DN;
                end
            end

            ST_SHIFT_DN:
            begin
                // age every entry by one position, oldest first
                ram_we    = 1'b1;
                ram_waddr = ptr_p1;
                ram_wdata = ram_rdata;
                ram_raddr = ptr_m1;
                if (ptr_reg == '0)
                begin
                    state_next = ST_INSERT;
                end
                else
                begin
                    ptr_next = ptr_m1;
                end
            end

            ST_INSERT:
            begin
                ram_we         = 1'b1;
                ram_waddr      = '0;
                ram_wdata.hnd  = req_handle_reg;
                ram_wdata.wid  = req_hwidth_reg;
                ram_wdata.hgt  = req_hheight_reg;
                count_next     = count_reg + CW'(1);
                res_valid_next = 1'b1;
                if (!pre_evict_reg && over_limit)
                begin
                    res_next   = make_result(KIND_STORED, req_handle_reg, req_hwidth_reg,
                                             req_hheight_reg, 1'b0);
                    state_next = ST_EV_RD;
                end
                else
                begin
                    res_next   = make_result(KIND_STORED, req_handle_reg, req_hwidth_reg,
                                             req_hheight_reg, 1'b1);
                    state_next = ST_IDLE;
                end
            end

            ST_EV_RD:
            begin
                ram_raddr  = cnt_m1[AW-1:0];
                state_next = ST_EV_OUT;
            end

            ST_EV_OUT:
            begin
                res_valid_next = 1'b1;
                res_next       = make_result(KIND_RELEASE, ram_rdata.hnd, ram_rdata.wid,
                                             ram_rdata.hgt, !pre_evict_reg);
                count_next     = cnt_m1;
                if (pre_evict_reg)
                begin
                    state_next = ST_INS_START;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_PURGE:
            begin
                ram_raddr      = ptr_p1;
                res_valid_next = 1'b1;
                res_next       = make_result(KIND_RELEASE, ram_rdata.hnd, ram_rdata.wid,
                                             ram_rdata.hgt, ptr_is_last);
                if (ptr_is_last)
                begin
                    count_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_p1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid = res_valid_reg;
    assign result_kind  = res_reg.kind;
    assign out_handle   = res_reg.hnd;
    assign out_width    = res_reg.wid;
    assign out_height   = res_reg.hgt;
    assign last         = res_reg.fin;

endmodule

// ===== rtl/core/klop_checker.sv =====
// port-level checks for the keyed lru object pool, bound to the top level
module klop_checker
    import klop_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              result_valid,
    input logic [KIND_W-1:0] result_kind,
    input logic              last
);

    // every result comes from a transaction that was in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
    else $error("result without a transaction in progress");

    // an accepted transaction makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

    // single-result kinds always close the transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_kind == KIND_HIT || result_kind == KIND_MISS ||
                          result_kind == KIND_NONE)) |-> last)
    else $error("hit, miss or nothing done without last");

    // more results pending means the block is still busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> busy)
    else $error("non-final result while idle");

endmodule

bind keyed_lru_object_pool_core klop_checker u_klop_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result_kind  (result_kind),
    .last         (last)
);
